// ----- rtl/rhsm_pkg.sv -----
`default_nettype none

package rhsm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = 5;
    localparam int INDEX_BITS  = 32;
    localparam int COUNT_W     = 32;
    localparam int HASH_W      = 7;
    localparam int HASH_MOD    = 101;
    localparam int BASE_MOD    = 256 % HASH_MOD;
    localparam int HASH_BIAS   = HASH_MOD * 253;
    localparam int RECIP       = 65536 / HASH_MOD;
    localparam int RECIP_SHIFT = 16;
    localparam int SUM_W       = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } text_in_t;

    typedef struct packed {
        logic                  hash_equal;
        logic                  match_found;
        logic [INDEX_BITS-1:0] match_start;
        logic [COUNT_W-1:0]    match_total;
        logic                  text_done;
    } result_t;

    typedef struct packed {
        logic [HASH_W-1:0]     hash;
        logic                  window_full;
        logic                  window_same;
        logic [INDEX_BITS-1:0] byte_index;
        logic                  text_end;
    } rec_t;

    typedef struct packed {
        logic              clear;
        logic [LEN_W-1:0]  used_len;
        logic [HASH_W-1:0] phash;
    } ctrl_t;

    // Reduces x modulo 101 by a reciprocal multiply and up to two corrective subtractions.
    function automatic logic [HASH_W-1:0] hash_mod(input logic [SUM_W-1:0] x);
        logic [SUM_W+9:0] prod;
        logic [8:0]       quot;
        logic [15:0]      rem;
        begin
            prod = (SUM_W + 10)'(x) * (SUM_W + 10)'(RECIP);
            quot = prod[RECIP_SHIFT +: 9];
            rem  = {1'b0, x} - 16'(quot) * 16'(HASH_MOD);
            if (rem >= 16'(HASH_MOD))
            begin
                rem = rem - 16'(HASH_MOD);
            end
            if (rem >= 16'(HASH_MOD))
            begin
                rem = rem - 16'(HASH_MOD);
            end
            return rem[HASH_W-1:0];
        end
    endfunction

    // 256 to the power len, modulo 101.
    function automatic logic [HASH_W-1:0] base_pow(input logic [LEN_W-1:0] len);
        logic [HASH_W-1:0] value;
        begin
            case (len)
                5'd1:    value = 7'd54;
                5'd2:    value = 7'd88;
                5'd3:    value = 7'd5;
                5'd4:    value = 7'd68;
                5'd5:    value = 7'd36;
                5'd6:    value = 7'd25;
                5'd7:    value = 7'd37;
                5'd8:    value = 7'd79;
                5'd9:    value = 7'd24;
                5'd10:   value = 7'd84;
                5'd11:   value = 7'd92;
                5'd12:   value = 7'd19;
                5'd13:   value = 7'd16;
                5'd14:   value = 7'd56;
                5'd15:   value = 7'd95;
                5'd16:   value = 7'd80;
                default: value = 7'd1;
            endcase
            return value;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rolling_hash_substring_matcher.sv -----
// A byte's record is registered in the input queue and its result then in the output
// buffer, where it can be taken. Throughput: one byte per cycle while full is low;
// two-entry queues decouple input, compare and output.
// After reset or a pattern register write, full stays high while the pattern hash is
// built one byte per cycle over the used pattern length (at most 16).
// Reset is asynchronous and active low; it clears the pattern, window, hash and counters.
`default_nettype none

module rolling_hash_substring_matcher (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    input  wire rhsm_pkg::text_in_t              in_item,
    output logic                                 full,
    output logic                                 empty,
    input  wire logic                            pop,
    output rhsm_pkg::result_t                    out_item,
    input  wire logic                            cfg_write,
    input  wire logic [rhsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rhsm_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    rhsm_pkg::rec_t  q_wr_rec;
    rhsm_pkg::rec_t  q_rd_rec;
    rhsm_pkg::ctrl_t ctrl;

    rhsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_item   (in_item),
        .full      (full),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (q_wr_rec),
        .ctrl      (ctrl)
    );

    rhsm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_rec (q_wr_rec),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_rec (q_rd_rec),
        .empty  (q_empty)
    );

    rhsm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .q_empty  (q_empty),
        .q_rec    (q_rd_rec),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

`ifndef SYNTHESIS
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (cfg_index == rhsm_pkg::CFG_PATTERN_LOW
                       || cfg_index == rhsm_pkg::CFG_PATTERN_HIGH
                       || cfg_index == rhsm_pkg::CFG_PATTERN_LENGTH)) |=> full)
        else $error("input not held off while the pattern hash is rebuilt");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("item written into a full queue");

    a_found_needs_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.match_found) |-> out_item.hash_equal)
        else $error("match reported without a hash hit");

    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_item.match_found) |-> (out_item.match_start == '0))
        else $error("match start nonzero without a match");
`endif

endmodule

`default_nettype wire

// ----- rtl/rhsm_front.sv -----
`default_nettype none

module rhsm_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    input  wire rhsm_pkg::text_in_t                   in_item,
    output logic                                      full,
    input  wire logic                                 cfg_write,
    input  wire logic [rhsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rhsm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 q_full,
    output logic                                      q_push,
    output rhsm_pkg::rec_t                            q_rec,
    output rhsm_pkg::ctrl_t                           ctrl
);

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_HASH = 2'b10
    } seq_state_t;

    seq_state_t                          state_reg;
    logic [rhsm_pkg::LEN_W-1:0]          step_reg;
    logic [rhsm_pkg::HASH_W-1:0]         phash_reg;
    logic [7:0]                          align_reg [rhsm_pkg::MAX_PATTERN];
    logic [7:0]                          align_next [rhsm_pkg::MAX_PATTERN];
    logic [rhsm_pkg::CFG_DATA_W-1:0]     pat_low_reg;
    logic [rhsm_pkg::CFG_DATA_W-1:0]     pat_high_reg;
    logic [rhsm_pkg::LEN_W-1:0]          plen_reg;
    logic [7:0]                          window_reg [rhsm_pkg::MAX_PATTERN];
    logic [7:0]                          window_next [rhsm_pkg::MAX_PATTERN];
    logic [rhsm_pkg::HASH_W-1:0]         hash_reg;
    logic [rhsm_pkg::HASH_W-1:0]         hash_next;
    logic [rhsm_pkg::INDEX_BITS-1:0]     seen_reg;
    logic [rhsm_pkg::INDEX_BITS-1:0]     seen_next;

    logic [2*rhsm_pkg::CFG_DATA_W-1:0]   pattern;
    logic [rhsm_pkg::LEN_W-1:0]          used_len;
    logic [rhsm_pkg::LEN_W-1:0]          lead_pos;
    logic [7:0]                          step_byte;
    logic [7:0]                          leave_byte;
    logic [rhsm_pkg::HASH_W-1:0]         horner;
    logic [rhsm_pkg::HASH_W-1:0]         roll;
    logic [rhsm_pkg::MAX_PATTERN-1:0]    eq_bits;
    logic                                cfg_hit;
    logic                                accept;

    assign pattern  = {pat_high_reg, pat_low_reg};
    assign used_len = (plen_reg > rhsm_pkg::LEN_W'(rhsm_pkg::MAX_PATTERN))
                      ? rhsm_pkg::LEN_W'(rhsm_pkg::MAX_PATTERN) : plen_reg;
    assign cfg_hit  = cfg_write && (cfg_index == rhsm_pkg::CFG_PATTERN_LOW
                      || cfg_index == rhsm_pkg::CFG_PATTERN_HIGH
                      || cfg_index == rhsm_pkg::CFG_PATTERN_LENGTH);
    assign full     = (state_reg != SEQ_IDLE) || q_full;
    assign accept   = push && !full;

    // The pattern hash is built by Horner's rule, one pattern byte per cycle.
    assign step_byte = pattern[{step_reg[3:0], 3'b000} +: 8];
    assign horner    = rhsm_pkg::hash_mod(
                           rhsm_pkg::SUM_W'(phash_reg) * rhsm_pkg::SUM_W'(rhsm_pkg::BASE_MOD)
                           + rhsm_pkg::SUM_W'(step_byte));

    always_comb
    begin
        logic [rhsm_pkg::LEN_W-1:0] pos;
        for (int j = 0; j < rhsm_pkg::MAX_PATTERN; j++)
        begin
            pos = used_len - rhsm_pkg::LEN_W'(1) - rhsm_pkg::LEN_W'(j);
            if (rhsm_pkg::LEN_W'(j) < used_len)
            begin
                align_next[j] = pattern[{pos[3:0], 3'b000} +: 8];
            end
            else
            begin
                align_next[j] = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            plen_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rhsm_pkg::CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                rhsm_pkg::CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                rhsm_pkg::CFG_PATTERN_LENGTH: plen_reg     <= cfg_data[rhsm_pkg::LEN_W-1:0];
                default:                      plen_reg     <= plen_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_HASH;
            step_reg  <= '0;
            phash_reg <= '0;
        end
        else if (cfg_hit)
        begin
            state_reg <= SEQ_HASH;
            step_reg  <= '0;
            phash_reg <= '0;
        end
        else
        begin
            case (state_reg)
                SEQ_HASH:
                begin
                    if (step_reg == used_len)
                    begin
                        state_reg <= SEQ_IDLE;
                    end
                    else
                    begin
                        phash_reg <= horner;
                        step_reg  <= step_reg + rhsm_pkg::LEN_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= SEQ_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SEQ_HASH)
        begin
            align_reg <= align_next;
        end
    end

    // Rolling update: h' = h*256 + b - leaving*256^m, all modulo 101.
    assign lead_pos   = used_len - rhsm_pkg::LEN_W'(1);
    assign leave_byte = window_reg[lead_pos[3:0]];
    assign roll       = rhsm_pkg::hash_mod(
                            rhsm_pkg::SUM_W'(hash_reg) * rhsm_pkg::SUM_W'(rhsm_pkg::BASE_MOD)
                            + rhsm_pkg::SUM_W'(in_item.text_byte)
                            + rhsm_pkg::SUM_W'(rhsm_pkg::HASH_BIAS)
                            - rhsm_pkg::SUM_W'(leave_byte)
                              * rhsm_pkg::SUM_W'(rhsm_pkg::base_pow(used_len)));
    assign hash_next  = (used_len == '0) ? hash_reg : roll;
    assign seen_next  = (seen_reg == '1) ? seen_reg
                        : seen_reg + rhsm_pkg::INDEX_BITS'(1);

    always_comb
    begin
        window_next[0] = in_item.text_byte;
        for (int j = 1; j < rhsm_pkg::MAX_PATTERN; j++)
        begin
            window_next[j] = window_reg[j-1];
        end
        for (int j = 0; j < rhsm_pkg::MAX_PATTERN; j++)
        begin
            eq_bits[j] = (window_next[j] == align_reg[j])
                         || (rhsm_pkg::LEN_W'(j) >= used_len);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < rhsm_pkg::MAX_PATTERN; j++)
            begin
                window_reg[j] <= '0;
            end
            hash_reg <= '0;
            seen_reg <= '0;
        end
        else if (cfg_hit || (accept && in_item.text_end))
        begin
            for (int j = 0; j < rhsm_pkg::MAX_PATTERN; j++)
            begin
                window_reg[j] <= '0;
            end
            hash_reg <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            hash_reg   <= hash_next;
            seen_reg   <= seen_next;
        end
    end

    assign q_push            = accept;
    assign q_rec.hash        = hash_next;
    assign q_rec.window_full = (used_len != '0)
                               && (seen_next >= rhsm_pkg::INDEX_BITS'(used_len));
    assign q_rec.window_same = &eq_bits;
    assign q_rec.byte_index  = seen_reg;
    assign q_rec.text_end    = in_item.text_end;

    assign ctrl.clear    = cfg_hit;
    assign ctrl.used_len = used_len;
    assign ctrl.phash    = phash_reg;

endmodule

`default_nettype wire

// ----- rtl/rhsm_queue.sv -----
`default_nettype none

module rhsm_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire rhsm_pkg::rec_t wr_rec,
    output logic                full,
    input  wire logic           rd_en,
    output rhsm_pkg::rec_t      rd_rec,
    output logic                empty
);

    rhsm_pkg::rec_t                 mem_reg [rhsm_pkg::QUEUE_DEPTH];
    logic [rhsm_pkg::PTR_W-1:0]     wr_ptr_reg;
    logic [rhsm_pkg::PTR_W-1:0]     rd_ptr_reg;
    logic [rhsm_pkg::CNT_W-1:0]     count_reg;
    logic [rhsm_pkg::CNT_W-1:0]     count_next;

    assign full   = count_reg == rhsm_pkg::CNT_W'(rhsm_pkg::QUEUE_DEPTH);
    assign empty  = count_reg == '0;
    assign rd_rec = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + rhsm_pkg::CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - rhsm_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + rhsm_pkg::PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + rhsm_pkg::PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rhsm_back.sv -----
`default_nettype none

module rhsm_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire rhsm_pkg::ctrl_t ctrl,
    input  wire logic            q_empty,
    input  wire rhsm_pkg::rec_t  q_rec,
    output logic                 q_pop,
    input  wire logic            pop,
    output logic                 empty,
    output rhsm_pkg::result_t    out_item
);

    rhsm_pkg::result_t                obuf_reg [rhsm_pkg::QUEUE_DEPTH];
    logic [rhsm_pkg::PTR_W-1:0]       owr_reg;
    logic [rhsm_pkg::PTR_W-1:0]       ord_reg;
    logic [rhsm_pkg::CNT_W-1:0]       ocount_reg;
    logic [rhsm_pkg::CNT_W-1:0]       ocount_next;
    logic [rhsm_pkg::COUNT_W-1:0]     counter_reg;
    logic [rhsm_pkg::COUNT_W-1:0]     counter_inc;
    logic [rhsm_pkg::COUNT_W-1:0]     total;
    logic                             hit;
    logic                             found;
    logic                             out_pop;
    rhsm_pkg::result_t                res;

    assign hit   = q_rec.window_full && (q_rec.hash == ctrl.phash);
    assign found = hit && q_rec.window_same;

    assign counter_inc = (counter_reg == '1) ? counter_reg
                         : counter_reg + rhsm_pkg::COUNT_W'(1);
    assign total       = found ? counter_inc : counter_reg;

    assign res.hash_equal  = hit;
    assign res.match_found = found;
    assign res.match_start = found
                             ? q_rec.byte_index - rhsm_pkg::INDEX_BITS'(ctrl.used_len)
                               + rhsm_pkg::INDEX_BITS'(1)
                             : '0;
    assign res.match_total = total;
    assign res.text_done   = q_rec.text_end;

    assign q_pop    = !q_empty && (ocount_reg != rhsm_pkg::CNT_W'(rhsm_pkg::QUEUE_DEPTH));
    assign empty    = ocount_reg == '0;
    assign out_pop  = pop && !empty;
    assign out_item = obuf_reg[ord_reg];

    always_comb
    begin
        ocount_next = ocount_reg;
        if (q_pop && !out_pop)
        begin
            ocount_next = ocount_reg + rhsm_pkg::CNT_W'(1);
        end
        else if (out_pop && !q_pop)
        begin
            ocount_next = ocount_reg - rhsm_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            obuf_reg[owr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg     <= '0;
            ord_reg     <= '0;
            ocount_reg  <= '0;
            counter_reg <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                owr_reg <= owr_reg + rhsm_pkg::PTR_W'(1);
            end
            if (out_pop)
            begin
                ord_reg <= ord_reg + rhsm_pkg::PTR_W'(1);
            end
            ocount_reg <= ocount_next;
            if (ctrl.clear)
            begin
                counter_reg <= '0;
            end
            else if (q_pop)
            begin
                counter_reg <= q_rec.text_end ? '0 : total;
            end
        end
    end

endmodule

`default_nettype wire
